// ===== design/aifp_pkg.sv =====
// ----------------------------------------------------------------------------
// aifp_pkg: shared types and constants of the ASCII integer field parser
// Phase and base codes, character constants, register indexes, and the
// control and result structs that pass between the parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package aifp_pkg;

    // Parse phases
    typedef enum logic [2:0] {
        PH_SKIP   = 3'd0,
        PH_PREFIX = 3'd1,
        PH_ZERO   = 3'd2,
        PH_DIGITS = 3'd3,
        PH_GROUP  = 3'd4,
        PH_AFTER  = 3'd5,
        PH_DONE   = 3'd6
    } phase_t;

    // Number bases (register codes 5..7 act as automatic)
    typedef enum logic [2:0] {
        B_AUTO = 3'd0,
        B_BIN  = 3'd1,
        B_OCT  = 3'd2,
        B_DEC  = 3'd3,
        B_HEX  = 3'd4
    } base_t;

    // Configuration register indexes
    localparam logic [1:0] REG_BASE_MODE = 2'd0;
    localparam logic [1:0] REG_MAX_WIDTH = 2'd1;
    localparam logic [1:0] REG_GROUPING  = 2'd2;
    localparam logic [1:0] REG_RES_SIZE  = 2'd3;

    // Result size codes
    localparam logic [1:0] SIZE_8  = 2'd0;
    localparam logic [1:0] SIZE_16 = 2'd1;
    localparam logic [1:0] SIZE_32 = 2'd2;
    localparam logic [1:0] SIZE_64 = 2'd3;

    // Reset values of the configuration registers
    localparam logic [2:0] BASE_MODE_RST = 3'd0;
    localparam logic [7:0] MAX_WIDTH_RST = 8'd0;
    localparam logic       GROUPING_RST  = 1'b0;
    localparam logic [1:0] RES_SIZE_RST  = SIZE_32;

    // Characters
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HT    = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_B  = 8'h62;
    localparam logic [7:0] CH_LO_X  = 8'h78;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;
    localparam logic [7:0] CASE_BIT = 8'h20;

    // Digit value that no base accepts
    localparam logic [5:0] NO_DIGIT = 6'd63;
    localparam logic [2:0] TALLY_MAX = 3'd4;

    // Parse control state (fixed widths)
    typedef struct packed {
        phase_t     phase;
        logic [2:0] tally;
        logic       neg;
        base_t      base;
        logic       group_live;
        logic       unlimited;
        logic [9:0] pend_group;
        logic [1:0] pend_fill;
    } parse_ctl_t;

    // Raw result handed to the output stage
    typedef struct packed {
        logic [63:0] acc;
        logic        neg;
        logic        valid;
        logic [1:0]  size;
    } result_t;

endpackage

`default_nettype wire

// ===== design/ascii_integer_field_parser.sv =====
// ----------------------------------------------------------------------------
// ascii_integer_field_parser: scans one integer field per text
// One text byte per item; one result item on the byte marked last.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  tdata[7:0] text_char, tlast text_last
//  m_*      out  m_tvalid/m_tready  tdata parsed_value, chars_consumed;
//                                   tuser field_valid
//  cfg_*    in   cfg_wr_en          cfg_index, cfg_data
//
//  One byte per cycle while the slave side is not stalled: a byte waits in the
//  input register while the parse update runs, and a result is loaded into the
//  output register at the edge where its last byte leaves the input register.
//  Reset restores the register defaults and clears the parse state and both
//  valid bits.
//  Only a last byte waiting on a full output register stalls the slave side.
// ----------------------------------------------------------------------------
`default_nettype none

module ascii_integer_field_parser #(
    parameter int COUNT_BITS = 12,
    parameter int WIDTH_BITS = 8
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    // slave side: tdata = text_char[7:0]; tlast = text_last
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,
    input  wire logic       s_tlast,
    // master side: tdata = parsed_value[63:0], chars_consumed, zero fill;
    // tuser = field_valid
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [((64+COUNT_BITS+7)/8)*8-1:0] m_tdata,
    output logic            m_tuser,
    // configuration write port
    input  wire logic       cfg_wr_en,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_data
);

    // Configuration registers
    logic [2:0] base_mode_reg;
    logic [7:0] max_width_reg;
    logic       grouping_reg;
    logic [1:0] res_size_reg;

    // Input register
    logic       in_valid_reg;
    logic [7:0] in_char_reg;
    logic       in_last_reg;

    // Parse state
    aifp_pkg::parse_ctl_t  ctl_reg;
    aifp_pkg::parse_ctl_t  ctl_next;
    logic [63:0]           acc_reg;
    logic [63:0]           acc_next;
    logic [WIDTH_BITS-1:0] width_left_reg;
    logic [WIDTH_BITS-1:0] width_left_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;

    aifp_pkg::result_t     result;
    logic [COUNT_BITS-1:0] result_count;
    logic                  out_free;
    logic                  advance;

    // Move the held byte on unless it is a last byte facing a full output
    assign advance  = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready = !in_valid_reg || advance;

    // Write configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_mode_reg <= aifp_pkg::BASE_MODE_RST;
            max_width_reg <= aifp_pkg::MAX_WIDTH_RST;
            grouping_reg  <= aifp_pkg::GROUPING_RST;
            res_size_reg  <= aifp_pkg::RES_SIZE_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                aifp_pkg::REG_BASE_MODE: base_mode_reg <= cfg_data[2:0];
                aifp_pkg::REG_MAX_WIDTH: max_width_reg <= cfg_data;
                aifp_pkg::REG_GROUPING:  grouping_reg  <= cfg_data[0];
                aifp_pkg::REG_RES_SIZE:  res_size_reg  <= cfg_data[1:0];
                default:                 base_mode_reg <= base_mode_reg;
            endcase
        end
    end

    // Hold the incoming item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Advance the parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg.phase      <= aifp_pkg::PH_SKIP;
            ctl_reg.tally      <= '0;
            ctl_reg.neg        <= 1'b0;
            ctl_reg.base       <= aifp_pkg::B_AUTO;
            ctl_reg.group_live <= 1'b0;
            ctl_reg.unlimited  <= 1'b0;
            ctl_reg.pend_group <= '0;
            ctl_reg.pend_fill  <= '0;
            acc_reg            <= '0;
            width_left_reg     <= '0;
            count_reg          <= '0;
        end
        else if (advance)
        begin
            ctl_reg        <= ctl_next;
            acc_reg        <= acc_next;
            width_left_reg <= width_left_next;
            count_reg      <= count_next;
        end
    end

    aifp_step #(
        .COUNT_BITS (COUNT_BITS),
        .WIDTH_BITS (WIDTH_BITS)
    ) u_step (
        .text_char       (in_char_reg),
        .text_last       (in_last_reg),
        .base_mode       (base_mode_reg),
        .max_width       (max_width_reg),
        .grouping_enable (grouping_reg),
        .result_size     (res_size_reg),
        .ctl             (ctl_reg),
        .acc             (acc_reg),
        .width_left      (width_left_reg),
        .count           (count_reg),
        .ctl_next        (ctl_next),
        .acc_next        (acc_next),
        .width_left_next (width_left_next),
        .count_next      (count_next),
        .result          (result),
        .result_count    (result_count)
    );

    aifp_out_stage #(
        .COUNT_BITS (COUNT_BITS)
    ) u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (advance && in_last_reg),
        .result       (result),
        .result_count (result_count),
        .m_tready     (m_tready),
        .m_tvalid     (m_tvalid),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .free         (out_free)
    );

    // A last byte that moves on shows up as a result
    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_last_reg |=> m_tvalid)
        else $error("last byte left without a result");

    // The slave side stalls only behind a blocked result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg && in_last_reg && m_tvalid && !m_tready)
        else $error("slave side stalled without a blocked result");

    // An invalid field reports a zero value
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[63:0] == 64'd0)
        else $error("invalid field with nonzero value");

    // A converted digit is always counted
    a_valid_counted: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[64 +: COUNT_BITS] != '0)
        else $error("valid field with zero characters consumed");

endmodule

`default_nettype wire

// ===== design/aifp_step.sv =====
// ----------------------------------------------------------------------------
// aifp_step: one-character parse update
// Combinational next state of the parser for one text byte, and the raw
// result on the last byte. Multiplies by the radix and by 1000 are shift-adds.
// ----------------------------------------------------------------------------
`default_nettype none

module aifp_step #(
    parameter int COUNT_BITS = 12,
    parameter int WIDTH_BITS = 8
) (
    input  wire logic [7:0]            text_char,
    input  wire logic                  text_last,
    input  wire logic [2:0]            base_mode,
    input  wire logic [7:0]            max_width,
    input  wire logic                  grouping_enable,
    input  wire logic [1:0]            result_size,
    input  wire aifp_pkg::parse_ctl_t  ctl,
    input  wire logic [63:0]           acc,
    input  wire logic [WIDTH_BITS-1:0] width_left,
    input  wire logic [COUNT_BITS-1:0] count,
    output aifp_pkg::parse_ctl_t       ctl_next,
    output logic [63:0]                acc_next,
    output logic [WIDTH_BITS-1:0]      width_left_next,
    output logic [COUNT_BITS-1:0]      count_next,
    output aifp_pkg::result_t          result,
    output logic [COUNT_BITS-1:0]      result_count
);

    localparam int CAP_W = (WIDTH_BITS > 8) ? WIDTH_BITS : 8;
    localparam logic [CAP_W-1:0] WIDTH_MAX = CAP_W'({WIDTH_BITS{1'b1}});
    localparam logic [COUNT_BITS:0] COUNT_MAX = {1'b0, {COUNT_BITS{1'b1}}};

    // Saturating add to the consumed count
    function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] cnt,
                                                   input logic [2:0] n);
        logic [COUNT_BITS:0] sum;
        sum = {1'b0, cnt} + (COUNT_BITS+1)'(n);
        return (sum > COUNT_MAX) ? COUNT_MAX[COUNT_BITS-1:0] : sum[COUNT_BITS-1:0];
    endfunction

    // Width remaining for n more characters
    function automatic logic room(input logic unl, input logic [WIDTH_BITS-1:0] wl,
                                  input logic [2:0] n);
        return unl || (wl >= WIDTH_BITS'(n));
    endfunction

    // Use up n characters of width, floor at zero
    function automatic logic [WIDTH_BITS-1:0] take(input logic unl,
                                                   input logic [WIDTH_BITS-1:0] wl,
                                                   input logic [2:0] n);
        logic [WIDTH_BITS-1:0] nw;
        nw = WIDTH_BITS'(n);
        if (unl)
            return wl;
        return (wl >= nw) ? wl - nw : '0;
    endfunction

    // Saturating digit tally
    function automatic logic [2:0] tally_add(input logic [2:0] t, input logic [2:0] n);
        logic [3:0] sum;
        sum = {1'b0, t} + {1'b0, n};
        return (sum > {1'b0, aifp_pkg::TALLY_MAX}) ? aifp_pkg::TALLY_MAX : sum[2:0];
    endfunction

    // Value of a digit character, any base up to 36
    function automatic logic [5:0] digit_value(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (c >= aifp_pkg::CH_ZERO && c <= aifp_pkg::CH_NINE)
            d = c - aifp_pkg::CH_ZERO;
        else if (c >= aifp_pkg::CH_LO_A && c <= aifp_pkg::CH_LO_Z)
            d = c - aifp_pkg::CH_LO_A + 8'd10;
        else if (c >= aifp_pkg::CH_UP_A && c <= aifp_pkg::CH_UP_Z)
            d = c - aifp_pkg::CH_UP_A + 8'd10;
        else
            d = {2'b00, aifp_pkg::NO_DIGIT};
        return d[5:0];
    endfunction

    function automatic logic [4:0] radix_of(input aifp_pkg::base_t b);
        logic [4:0] r;
        unique case (b)
            aifp_pkg::B_BIN: r = 5'd2;
            aifp_pkg::B_OCT: r = 5'd8;
            aifp_pkg::B_DEC: r = 5'd10;
            aifp_pkg::B_HEX: r = 5'd16;
            default:         r = 5'd0;
        endcase
        return r;
    endfunction

    // Working copies of the state
    aifp_pkg::parse_ctl_t  s;
    logic [63:0]           a;
    logic [WIDTH_BITS-1:0] wl;
    logic [COUNT_BITS-1:0] cnt;
    logic                  go_prefix;
    logic                  go_digits;
    logic                  is_space;
    logic [7:0]            low_c;
    logic [5:0]            dval;
    logic [63:0]           a_scaled;
    logic [9:0]            pg_new;
    logic [CAP_W-1:0]      mw_ext;

    always_comb
    begin
        s         = ctl;
        a         = acc;
        wl        = width_left;
        cnt       = count;
        go_prefix = 1'b0;
        go_digits = 1'b0;
        is_space  = (text_char == aifp_pkg::CH_SPACE) ||
                    (text_char >= aifp_pkg::CH_HT && text_char <= aifp_pkg::CH_CR);
        low_c     = text_char | aifp_pkg::CASE_BIT;
        dval      = digit_value(text_char);
        mw_ext    = CAP_W'(max_width);
        a_scaled  = '0;
        pg_new    = '0;

        // First step from the stored phase
        unique case (ctl.phase)
            aifp_pkg::PH_SKIP:
            begin
                if (is_space)
                    cnt = bump(cnt, 3'd1);
                else
                begin
                    // Open the field with the current configuration
                    s.unlimited  = (max_width == 8'd0);
                    wl           = (mw_ext > WIDTH_MAX) ? WIDTH_MAX[WIDTH_BITS-1:0]
                                                        : mw_ext[WIDTH_BITS-1:0];
                    s.base       = (base_mode <= 3'(aifp_pkg::B_HEX))
                                   ? aifp_pkg::base_t'(base_mode) : aifp_pkg::B_AUTO;
                    s.group_live = grouping_enable;
                    if (text_char == aifp_pkg::CH_MINUS || text_char == aifp_pkg::CH_PLUS)
                    begin
                        s.neg   = (text_char == aifp_pkg::CH_MINUS);
                        cnt     = bump(cnt, 3'd1);
                        wl      = take(s.unlimited, wl, 3'd1);
                        s.phase = aifp_pkg::PH_PREFIX;
                    end
                    else
                        go_prefix = 1'b1;
                end
            end
            aifp_pkg::PH_PREFIX:
                go_prefix = 1'b1;
            aifp_pkg::PH_ZERO:
            begin
                if (room(s.unlimited, wl, 3'd2) && low_c == aifp_pkg::CH_LO_X &&
                    (s.base == aifp_pkg::B_AUTO || s.base == aifp_pkg::B_HEX))
                begin
                    s.base       = aifp_pkg::B_HEX;
                    s.group_live = 1'b0;
                    cnt          = bump(cnt, 3'd2);
                    wl           = take(s.unlimited, wl, 3'd2);
                    s.phase      = aifp_pkg::PH_DIGITS;
                end
                else if (room(s.unlimited, wl, 3'd2) && low_c == aifp_pkg::CH_LO_B &&
                         (s.base == aifp_pkg::B_AUTO || s.base == aifp_pkg::B_BIN))
                begin
                    s.base       = aifp_pkg::B_BIN;
                    s.group_live = 1'b0;
                    cnt          = bump(cnt, 3'd2);
                    wl           = take(s.unlimited, wl, 3'd2);
                    s.phase      = aifp_pkg::PH_DIGITS;
                end
                else
                begin
                    // The zero is an ordinary digit
                    if (s.base == aifp_pkg::B_AUTO)
                    begin
                        s.base       = aifp_pkg::B_OCT;
                        s.group_live = 1'b0;
                    end
                    a         = '0;
                    s.tally   = tally_add(s.tally, 3'd1);
                    cnt       = bump(cnt, 3'd1);
                    wl        = take(s.unlimited, wl, 3'd1);
                    go_digits = 1'b1;
                end
            end
            aifp_pkg::PH_DIGITS:
                go_digits = 1'b1;
            aifp_pkg::PH_GROUP:
            begin
                if (text_char >= aifp_pkg::CH_ZERO && text_char <= aifp_pkg::CH_NINE)
                begin
                    pg_new = (s.pend_group << 3) + (s.pend_group << 1) +
                             10'(text_char - aifp_pkg::CH_ZERO);
                    if (s.pend_fill == 2'd2)
                    begin
                        // Complete group: times 1000 as 1024 - 16 - 8
                        a            = (a << 10) - (a << 4) - (a << 3) + 64'(pg_new);
                        s.pend_group = '0;
                        s.pend_fill  = '0;
                        s.tally      = tally_add(s.tally, 3'd3);
                        cnt          = bump(cnt, 3'd4);
                        wl           = take(s.unlimited, wl, 3'd4);
                        s.phase      = aifp_pkg::PH_AFTER;
                    end
                    else
                    begin
                        s.pend_group = pg_new;
                        s.pend_fill  = s.pend_fill + 2'd1;
                    end
                end
                else
                    s.phase = aifp_pkg::PH_DONE;
            end
            aifp_pkg::PH_AFTER:
            begin
                if (text_char == aifp_pkg::CH_COMMA && room(s.unlimited, wl, 3'd4))
                begin
                    s.pend_group = '0;
                    s.pend_fill  = '0;
                    s.phase      = aifp_pkg::PH_GROUP;
                end
                else
                    s.phase = aifp_pkg::PH_DONE;
            end
            default:
                s.phase = ctl.phase;
        endcase

        // Sign or prefix position
        if (go_prefix)
        begin
            if (room(s.unlimited, wl, 3'd1) && text_char == aifp_pkg::CH_ZERO)
                s.phase = aifp_pkg::PH_ZERO;
            else
            begin
                if (s.base == aifp_pkg::B_AUTO)
                    s.base = aifp_pkg::B_DEC;
                go_digits = 1'b1;
            end
        end

        // Digit position: accumulate, open a group, or end the field
        if (go_digits)
        begin
            s.phase = aifp_pkg::PH_DONE;
            unique case (s.base)
                aifp_pkg::B_BIN: a_scaled = a << 1;
                aifp_pkg::B_OCT: a_scaled = a << 3;
                aifp_pkg::B_DEC: a_scaled = (a << 3) + (a << 1);
                aifp_pkg::B_HEX: a_scaled = a << 4;
                default:         a_scaled = a;
            endcase
            if (room(s.unlimited, wl, 3'd1) && (dval < {1'b0, radix_of(s.base)}))
            begin
                a       = a_scaled + 64'(dval);
                s.tally = tally_add(s.tally, 3'd1);
                cnt     = bump(cnt, 3'd1);
                wl      = take(s.unlimited, wl, 3'd1);
                s.phase = aifp_pkg::PH_DIGITS;
            end
            else if (s.group_live && s.base == aifp_pkg::B_DEC &&
                     text_char == aifp_pkg::CH_COMMA &&
                     room(s.unlimited, wl, 3'd4) && s.tally >= 3'd1 && s.tally <= 3'd3)
            begin
                s.pend_group = '0;
                s.pend_fill  = '0;
                s.phase      = aifp_pkg::PH_GROUP;
            end
        end

        // Text ends right after a zero: it counts as a digit
        if (text_last && s.phase == aifp_pkg::PH_ZERO)
        begin
            a       = '0;
            s.tally = tally_add(s.tally, 3'd1);
            cnt     = bump(cnt, 3'd1);
        end

        result.acc   = a;
        result.neg   = s.neg;
        result.valid = (s.tally != 3'd0);
        result.size  = result_size;
        result_count = cnt;

        // Restart the parse after the last byte
        if (text_last)
        begin
            ctl_next.phase      = aifp_pkg::PH_SKIP;
            ctl_next.tally      = '0;
            ctl_next.neg        = 1'b0;
            ctl_next.base       = aifp_pkg::B_AUTO;
            ctl_next.group_live = 1'b0;
            ctl_next.unlimited  = 1'b0;
            ctl_next.pend_group = '0;
            ctl_next.pend_fill  = '0;
            acc_next            = '0;
            width_left_next     = '0;
            count_next          = '0;
        end
        else
        begin
            ctl_next        = s;
            acc_next        = a;
            width_left_next = wl;
            count_next      = cnt;
        end
    end

endmodule

`default_nettype wire

// ===== design/aifp_out_stage.sv =====
// ----------------------------------------------------------------------------
// aifp_out_stage: result register of the parser
// Holds one result until the master side takes it; the sign and the result
// size mask are applied to the held result and the output item is packed.
// ----------------------------------------------------------------------------
`default_nettype none

module aifp_out_stage #(
    parameter int COUNT_BITS = 12
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  load,
    input  wire aifp_pkg::result_t     result,
    input  wire logic [COUNT_BITS-1:0] result_count,
    input  wire logic                  m_tready,
    output logic                       m_tvalid,
    output logic [((64+COUNT_BITS+7)/8)*8-1:0] m_tdata,
    output logic                       m_tuser,
    output logic                       free
);

    localparam int DATA_W = ((64 + COUNT_BITS + 7) / 8) * 8;

    logic                  valid_reg;
    aifp_pkg::result_t     res_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic [63:0]           signed_val;
    logic [63:0]           size_mask;

    assign free = !valid_reg || m_tready;

    // Track an item waiting on the master side
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (m_tready)
            valid_reg <= 1'b0;
    end

    // Capture the raw result
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg   <= result;
            count_reg <= result_count;
        end
    end

    // Sign and size the value
    always_comb
    begin
        signed_val = res_reg.neg ? (64'd0 - res_reg.acc) : res_reg.acc;
        unique case (res_reg.size)
            aifp_pkg::SIZE_8:  size_mask = 64'h0000_0000_0000_00FF;
            aifp_pkg::SIZE_16: size_mask = 64'h0000_0000_0000_FFFF;
            aifp_pkg::SIZE_32: size_mask = 64'h0000_0000_FFFF_FFFF;
            aifp_pkg::SIZE_64: size_mask = 64'hFFFF_FFFF_FFFF_FFFF;
            default:           size_mask = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = res_reg.valid;
    assign m_tdata  = DATA_W'({count_reg, res_reg.valid ? (signed_val & size_mask) : 64'd0});

endmodule

`default_nettype wire
